>>> src/bpc_pkg.sv
// Shared types and constants for the button press classifier.
`default_nettype none

package bpc_pkg;

    localparam int unsigned LONG_W  = 10;
    localparam int unsigned SHORT_W = 10;
    localparam int unsigned IDLE_W  = 16;
    localparam int unsigned PRESS_W = 11;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [LONG_W-1:0]  LONG_RESET  = 10'd600;
    localparam logic [SHORT_W-1:0] SHORT_RESET = 10'd10;
    localparam logic [IDLE_W-1:0]  IDLE_RESET  = 16'd7000;

    localparam logic [PRESS_W-1:0] PRESS_MAX = {PRESS_W{1'b1}};
    localparam logic [IDLE_W-1:0]  IDLE_MAX  = {IDLE_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 2'd2;

    // Command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_WAKE = 1'b1;

    typedef enum logic [1:0] {
        CLICK_NONE  = 2'd0,
        CLICK_SHORT = 2'd1,
        CLICK_LONG  = 2'd2
    } click_kind_t;

    typedef struct packed {
        logic [LONG_W-1:0]  long_press_ticks;
        logic [SHORT_W-1:0] short_min_ticks;
        logic [IDLE_W-1:0]  idle_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic command;
        logic button_level;
        logic sleep_enable;
    } item_t;

    typedef struct packed {
        click_kind_t click_kind;
        logic        sleep_request;
    } result_t;

endpackage

`default_nettype wire

>>> src/button_press_classifier_core.sv
// Top level of the button press classifier: input stage, classifier, result register.
// An accepted beat is held in the input register, then classified into the result register (m_tdata).
// Throughput: one beat per cycle while no configuration write is pending; the input register
// and result register advance together whenever the result register is empty or being taken.
// Reset (rst_n low, asynchronous): both stages empty, counters and sleep cleared,
// thresholds back to 600 / 10 / 7000 ticks. Config writes wait for an empty input stage.
`default_nettype none

module button_press_classifier_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] button_level, [1] sleep_enable, [7:2] zero
    input  wire logic        s_tuser,   // [0] command (0 tick, 1 wake)
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [1:0] click_kind, [2] sleep_request, [7:3] zero
    // Configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bpc_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t res;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    advance;

    // Move the held beat into the result register when that register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    // Hold off new input beats while a configuration write is pending
    assign s_tready = (!in_valid_reg || advance) && !cfg_valid;
    // Take a write only once no beat waits for classification
    assign cfg_ready = !in_valid_reg;

    bpc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Input stage: hold the beat until the classifier consumes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.command      <= s_tuser;
            in_item_reg.button_level <= s_tdata[0];
            in_item_reg.sleep_enable <= s_tdata[1];
        end
    end

    // Counters update exactly once per beat, when it advances
    bpc_classify u_classify (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // Result register: hold until the downstream side takes the beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_res_reg.sleep_request, out_res_reg.click_kind};

endmodule

`default_nettype wire

>>> src/bpc_cfg_regs.sv
// Configuration register file for the button press classifier.
`default_nettype none

module bpc_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            wr_en,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0]   wr_index,
    input  wire logic [bpc_pkg::CFG_DATA_W-1:0]  wr_data,
    output bpc_pkg::cfg_t                        cfg
);
    import bpc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks   <= LONG_RESET;
            cfg_reg.short_min_ticks    <= SHORT_RESET;
            cfg_reg.idle_timeout_ticks <= IDLE_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_LONG_PRESS:   cfg_reg.long_press_ticks   <= wr_data[LONG_W-1:0];
                CFG_SHORT_MIN:    cfg_reg.short_min_ticks    <= wr_data[SHORT_W-1:0];
                CFG_IDLE_TIMEOUT: cfg_reg.idle_timeout_ticks <= wr_data[IDLE_W-1:0];
                default:          ; // drop writes to unused indexes
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> src/bpc_classify.sv
// Press and idle counters with the click and sleep decision logic.
`default_nettype none

module bpc_classify (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     fire,
    input  wire bpc_pkg::item_t  item,
    input  wire bpc_pkg::cfg_t   cfg,
    output bpc_pkg::result_t res
);
    import bpc_pkg::*;

    logic [PRESS_W-1:0] press_count_reg, press_count_next;
    logic [IDLE_W-1:0]  idle_count_reg,  idle_count_next;
    logic               asleep_reg,      asleep_next;
    click_kind_t        kind;

    always_comb
    begin
        press_count_next = press_count_reg;
        idle_count_next  = idle_count_reg;
        asleep_next      = asleep_reg;
        kind             = CLICK_NONE;
        if (item.command == CMD_WAKE)
        begin
            idle_count_next = '0;
            asleep_next     = 1'b0;
        end
        else if (!asleep_reg)
        begin
            if (!item.button_level)
            begin
                if (press_count_reg > {1'b0, cfg.long_press_ticks})
                begin
                    kind             = CLICK_LONG;
                    press_count_next = '0;
                end
                else if (press_count_reg != PRESS_MAX)
                begin
                    press_count_next = press_count_reg + 1'b1;
                end
            end
            else if (press_count_reg >= {1'b0, cfg.short_min_ticks})
            begin
                kind             = CLICK_SHORT;
                press_count_next = '0;
            end
            else
            begin
                if (item.sleep_enable && idle_count_reg != IDLE_MAX)
                    idle_count_next = idle_count_reg + 1'b1;
                if (idle_count_next > cfg.idle_timeout_ticks)
                    asleep_next = 1'b1;
                press_count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_count_reg <= '0;
            idle_count_reg  <= '0;
            asleep_reg      <= 1'b0;
        end
        else if (fire)
        begin
            press_count_reg <= press_count_next;
            idle_count_reg  <= idle_count_next;
            asleep_reg      <= asleep_next;
        end
    end

    assign res.click_kind    = kind;
    assign res.sleep_request = asleep_next;

    // Ticks while asleep leave all counters untouched
    a_asleep_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.command == CMD_TICK && asleep_reg
        |=> $stable(press_count_reg) && $stable(idle_count_reg) && asleep_reg)
        else $error("tick while asleep changed state");

    // A wake beat clears idle count and sleep
    a_wake_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.command == CMD_WAKE
        |=> idle_count_reg == '0 && !asleep_reg)
        else $error("wake did not clear idle state");

    // Any reported click restarts the press counter
    a_click_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && kind != CLICK_NONE |=> press_count_reg == '0)
        else $error("press counter not cleared after click");

endmodule

`default_nettype wire
